[rtl/bfiq_pkg.sv]
package bfiq_pkg;

    localparam int KEY_W            = 16;
    localparam int BYTE_W           = 8;
    localparam int DIGEST_W         = 160;
    localparam int ROW_BITS         = 64;
    localparam int MAX_BITS_DEFAULT = 65536;

    localparam int CMD_W      = 2;
    localparam int HASH_CNT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STORE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 2'd1;

    localparam logic [KEY_W-1:0]      WIDTH_RESET   = 16'hFFFF;
    localparam logic [HASH_CNT_W-1:0] COUNT_RESET   = 5'd4;
    localparam logic [HASH_CNT_W-1:0] SLICES_NARROW = 5'd19;
    localparam logic [HASH_CNT_W-1:0] SLICES_WIDE   = 5'd9;
    localparam logic [KEY_W-1:0]      NARROW_MAX    = 16'd255;

    localparam int DIGIT_BITS   = 4;
    localparam int WIDE_STEPS   = KEY_W / DIGIT_BITS;
    localparam int NARROW_STEPS = BYTE_W / DIGIT_BITS;
    localparam int STEP_W       = $clog2(WIDE_STEPS);

    typedef struct packed {
        logic             start;
        logic             narrow;
        logic [KEY_W-1:0] raw;
    } mod_req_t;

endpackage

[rtl/bloom_filter_insert_query_unit.sv]
// Query/insert: each hash index (16-bit or 8-bit) comes from the modulo unit (four remainder bits a cycle),
// followed by the row store read-modify-write.
// A query result is registered and held until accepted; no new item is taken until one is done.
// Clear command and reset: a sweep over MAX_BITS/64 rows (1024 at default) zeroes the store,
// input held off meanwhile. Registers reset to store width 65535, hash count 4.
module bloom_filter_insert_query_unit
    import bfiq_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [63:0]           digest_upper,
    input  logic [63:0]           digest_middle,
    input  logic [31:0]           digest_lower,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  present,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W    = $clog2(MAX_BITS);
    localparam int BIT_SEL_W = $clog2(ROW_BITS);
    localparam int ROWS      = MAX_BITS / ROW_BITS;
    localparam int ROW_A_W   = ADDR_W - BIT_SEL_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_UPD,
        ST_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  present_reg, present_next;
    logic                  all_reg, all_next;
    logic [HASH_CNT_W-1:0] left_reg, left_next;
    logic [ROW_A_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [KEY_W-1:0]      store_width_reg;
    logic [HASH_CNT_W-1:0] hash_count_reg;

    logic [DIGEST_W-1:0]   digest_reg, digest_next;
    logic [KEY_W-1:0]      w_reg, w_next;
    logic                  narrow_reg, narrow_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [ADDR_W-1:0]     idx_reg;

    logic [ROW_BITS-1:0]   mem [ROWS];
    logic [ROW_BITS-1:0]   rd_data_reg;
    logic                  mem_we;
    logic [ROW_A_W-1:0]    mem_addr;
    logic [ROW_BITS-1:0]   mem_wdata;

    mod_req_t              mod_req;
    logic                  mod_done;
    logic [KEY_W-1:0]      mod_rem;

    logic                  in_fire;
    logic [KEY_W-1:0]      w_eff;
    logic                  narrow_eff;
    logic [HASH_CNT_W-1:0] limit;
    logic [HASH_CNT_W-1:0] count;
    logic                  bit_val;
    logic [ADDR_W-1:0]     mod_idx;

    bfiq_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mod_req),
        .divisor (w_reg),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign present   = present_reg;

    assign w_eff      = (store_width_reg == '0) ? KEY_W'(1) : store_width_reg;
    assign narrow_eff = (w_eff <= NARROW_MAX);
    assign limit      = narrow_eff ? SLICES_NARROW : SLICES_WIDE;
    assign count      = (hash_count_reg < limit) ? hash_count_reg : limit;
    assign bit_val    = rd_data_reg[idx_reg[BIT_SEL_W-1:0]];
    assign mod_idx    = mod_rem[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        present_next   = present_reg;
        all_next       = all_reg;
        left_next      = left_reg;
        clr_cnt_next   = clr_cnt_reg;
        digest_next    = digest_reg;
        w_next         = w_reg;
        narrow_next    = narrow_reg;
        mod_req        = '{start: 1'b0, narrow: narrow_reg, raw: digest_reg[DIGEST_W-1 -: KEY_W]};
        mem_we         = 1'b0;
        mem_addr       = idx_reg[ADDR_W-1:BIT_SEL_W];
        mem_wdata      = rd_data_reg | (ROW_BITS'(1) << idx_reg[BIT_SEL_W-1:0]);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_A_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    digest_next = {digest_upper, digest_middle, digest_lower};
                    w_next      = w_eff;
                    narrow_next = narrow_eff;
                    all_next    = 1'b1;
                    left_next   = count;
                    if (cmd == CMD_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    else if (cmd == CMD_QUERY || cmd == CMD_INSERT)
                    begin
                        if (count == '0)
                        begin
                            state_next = (cmd == CMD_QUERY) ? ST_RESULT : ST_IDLE;
                        end
                        else
                        begin
                            mod_req    = '{start: 1'b1, narrow: narrow_eff,
                                           raw: digest_upper[63 -: KEY_W]};
                            state_next = ST_MOD;
                        end
                    end
                end
            end
            ST_MOD:
            begin
                mem_addr = mod_idx[ADDR_W-1:BIT_SEL_W];
                if (mod_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                all_next    = all_reg & bit_val;
                mem_we      = (cmd_reg == CMD_INSERT);
                left_next   = left_reg - 1'b1;
                digest_next = narrow_reg ? (digest_reg << BYTE_W) : (digest_reg << KEY_W);
                if (left_reg == HASH_CNT_W'(1))
                begin
                    state_next = (cmd_reg == CMD_QUERY) ? ST_RESULT : ST_IDLE;
                end
                else
                begin
                    mod_req    = '{start: 1'b1, narrow: narrow_reg,
                                   raw: digest_next[DIGEST_W-1 -: KEY_W]};
                    state_next = ST_MOD;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    present_next   = all_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            out_valid_reg   <= 1'b0;
            present_reg     <= 1'b0;
            all_reg         <= 1'b1;
            left_reg        <= '0;
            clr_cnt_reg     <= '0;
            store_width_reg <= WIDTH_RESET;
            hash_count_reg  <= COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            present_reg   <= present_next;
            all_reg       <= all_next;
            left_reg      <= left_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STORE_WIDTH)
                begin
                    store_width_reg <= cfg_data[KEY_W-1:0];
                end
                else if (cfg_index == CFG_HASH_COUNT)
                begin
                    hash_count_reg <= cfg_data[HASH_CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
        w_reg      <= w_next;
        narrow_reg <= narrow_next;
        if (in_fire)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_MOD && mod_done)
        begin
            idx_reg <= mod_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == ST_MOD)
        else $error("modulo result outside index wait");

    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_UPD && cmd_reg == CMD_INSERT))
        else $error("store write outside clear or insert update");

    a_left_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_UPD) |-> left_reg != '0)
        else $error("index loop running with no hashes left");

    a_clear_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == CMD_CLEAR) |=> state_reg == ST_CLEAR && clr_cnt_reg == '0)
        else $error("clear item did not start sweep");

endmodule

[rtl/bfiq_mod.sv]
module bfiq_mod
    import bfiq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mod_req_t         req,
    input  logic [KEY_W-1:0] divisor,
    output logic             done,
    output logic [KEY_W-1:0] rem
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [KEY_W-1:0]  rem_reg;
    logic [KEY_W:0]    r_next;
    logic [KEY_W-1:0]  dvd_next;

    always_comb
    begin
        r_next   = {1'b0, rem_reg};
        dvd_next = dvd_reg;
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            r_next   = {r_next[KEY_W-1:0], dvd_next[KEY_W-1]};
            dvd_next = {dvd_next[KEY_W-2:0], 1'b0};
            if (r_next >= {1'b0, divisor})
            begin
                r_next = r_next - {1'b0, divisor};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= req.narrow ? STEP_W'(NARROW_STEPS - 1) : STEP_W'(WIDE_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.raw;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= r_next[KEY_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[dv/bloom_filter_insert_query_unit_tb.sv]
module bloom_filter_insert_query_unit_tb;
    import bfiq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES   = MAX_BITS_DEFAULT / ROW_BITS + 200;
    localparam int TAIL_CYCLES     = 200;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int POOL_DEPTH      = 32;

    class membership_scoreboard;
        bit                    cells[MAX_BITS_DEFAULT];
        logic [KEY_W-1:0]      width_reg;
        logic [HASH_CNT_W-1:0] count_reg;
        bit                    present_due[$];
        int                    errors;
        int                    checked;
        int                    inserts;
        int                    queries;
        int                    hits;
        int                    clears;
        int                    ignored;
        int                    reg_writes;

        function new();
            width_reg = WIDTH_RESET;
            count_reg = COUNT_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_STORE_WIDTH: width_reg = data[KEY_W-1:0];
                CFG_HASH_COUNT:  count_reg = data[HASH_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned cell_index(logic [DIGEST_W-1:0] dg, int unsigned h,
                                         int unsigned w);
            int unsigned raw;
            if (w <= 32'(NARROW_MAX))
                raw = 32'(dg[DIGEST_W-1-BYTE_W*h -: BYTE_W]);
            else
                raw = 32'(dg[DIGEST_W-1-KEY_W*h -: KEY_W]);
            return (raw % w) % MAX_BITS_DEFAULT;
        endfunction

        function void accept_item(logic [CMD_W-1:0] cmd, logic [DIGEST_W-1:0] dg);
            int unsigned w;
            int unsigned lim;
            int unsigned n;
            bit          all_set;
            w = (width_reg == '0) ? 1 : 32'(width_reg);
            lim = (w <= 32'(NARROW_MAX)) ? 32'(SLICES_NARROW) : 32'(SLICES_WIDE);
            n = (32'(count_reg) < lim) ? 32'(count_reg) : lim;
            case (cmd)
                CMD_CLEAR:
                begin
                    foreach (cells[i])
                        cells[i] = 1'b0;
                    clears++;
                end
                CMD_INSERT:
                begin
                    for (int unsigned h = 0; h < n; h++)
                        cells[cell_index(dg, h, w)] = 1'b1;
                    inserts++;
                end
                CMD_QUERY:
                begin
                    all_set = 1'b1;
                    for (int unsigned h = 0; h < n; h++)
                        if (!cells[cell_index(dg, h, w)])
                            all_set = 1'b0;
                    present_due = {present_due, all_set};
                    queries++;
                    if (all_set)
                        hits++;
                end
                default: ignored++;
            endcase
        endfunction

        function void check_present(logic got);
            bit want;
            if (present_due.size() == 0)
            begin
                $error("present: no query outstanding, expected none, got %0b", got);
                errors++;
                return;
            end
            want = present_due.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("present mismatch: expected %0b, got %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd           = CMD_QUERY;
    logic [63:0]           digest_upper  = '0;
    logic [63:0]           digest_middle = '0;
    logic [31:0]           digest_lower  = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic                  present;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_STORE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    membership_scoreboard  sb = new();
    logic [DIGEST_W-1:0]   inserted[$];
    bit                    tx_steady     = 1'b0;
    bit                    rx_steady     = 1'b0;
    bit                    hold_request  = 1'b0;
    int unsigned           cycles        = 0;

    bloom_filter_insert_query_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .digest_upper  (digest_upper),
        .digest_middle (digest_middle),
        .digest_lower  (digest_lower),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .present       (present),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned idle_span(bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    function automatic logic [DIGEST_W-1:0] random_digest();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // hold valid and payload until accepted, then leave valid up unless a gap follows
    task automatic offer(logic [CMD_W-1:0] c, logic [DIGEST_W-1:0] dg);
        int unsigned gap;
        in_valid      <= 1'b1;
        cmd           <= c;
        digest_upper  <= dg[159:96];
        digest_middle <= dg[95:32];
        digest_lower  <= dg[31:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.accept_item(c, dg);
        if (c == CMD_INSERT)
        begin
            inserted = {inserted, dg};
            if (inserted.size() > POOL_DEPTH)
                void'(inserted.pop_front());
        end
        gap = idle_span(tx_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.present_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // wait out any clear sweep, then write both registers back to back
    task automatic apply_config(logic [CFG_DATA_W-1:0] width_data,
                                logic [CFG_DATA_W-1:0] count_data, bit touch_unused);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        push_reg(CFG_STORE_WIDTH, width_data);
        push_reg(CFG_HASH_COUNT, count_data);
        if (touch_unused)
            push_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned         r;
        logic [DIGEST_W-1:0] dg;
        r = $urandom_range(0, 99);
        dg = random_digest();
        if (r < 2)
            offer(CMD_CLEAR, dg);
        else if (r < 5)
            offer(CMD_UNUSED, dg);
        else if (r < 40)
            offer(CMD_INSERT, dg);
        else
        begin
            if (inserted.size() != 0 && $urandom_range(0, 99) < 60)
            begin
                dg = inserted[$urandom_range(0, inserted.size() - 1)];
                if ($urandom_range(0, 3) == 0)
                    dg[$urandom_range(0, DIGEST_W - 1)] ^= 1'b1;
            end
            offer(CMD_QUERY, dg);
        end
    endtask

    initial
    begin
        int unsigned stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_present(present);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall = idle_span(rx_steady);
                if (stall > 0)
                begin
                    stall--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d queries unanswered",
                 cycles, sb.present_due.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [DIGEST_W-1:0]   key_a;
        logic [DIGEST_W-1:0]   ones;
        logic [CFG_DATA_W-1:0] width_plan[PHASES];
        logic [HASH_CNT_W-1:0] count_plan[PHASES];

        key_a = random_digest();
        ones  = '1;
        width_plan = '{16'hFFFF, CFG_DATA_W'($urandom_range(2, 254)), 16'd255,
                       CFG_DATA_W'($urandom), 16'd256, 16'd0, 16'd1,
                       CFG_DATA_W'($urandom_range(257, 600))};
        count_plan = '{5'd9, 5'd19, 5'd31, HASH_CNT_W'($urandom_range(1, 8)), 5'd31,
                       5'd2, 5'd0, HASH_CNT_W'($urandom_range(1, 31))};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: wide indices, four hashes
        offer(CMD_INSERT, key_a);
        offer(CMD_QUERY, key_a);
        offer(CMD_QUERY, '0);
        offer(CMD_INSERT, ones);
        offer(CMD_QUERY, ones);
        offer(CMD_QUERY, '0);
        offer(CMD_UNUSED, ones);
        offer(CMD_CLEAR, ones);
        offer(CMD_QUERY, key_a);
        offer(CMD_QUERY, '0);

        // zero width: every index lands on cell zero
        apply_config(16'd0, 16'hFFE1, 1'b0);
        offer(CMD_QUERY, random_digest());
        offer(CMD_INSERT, random_digest());
        offer(CMD_QUERY, random_digest());

        // widest narrow store, hash count clamped to the byte slices
        apply_config(16'd255, 16'h001F, 1'b0);
        offer(CMD_INSERT, ones);
        offer(CMD_QUERY, ones);
        offer(CMD_QUERY, key_a);

        // narrowest wide store, clamped to the 16-bit slices
        apply_config(16'd256, 16'hFF3F, 1'b0);
        offer(CMD_INSERT, key_a);
        offer(CMD_QUERY, key_a);
        offer(CMD_QUERY, ones);

        // no hashes: insert is a no-op and query always hits
        apply_config(16'd1, 16'hFFE0, 1'b1);
        offer(CMD_QUERY, random_digest());
        offer(CMD_INSERT, random_digest());
        offer(CMD_CLEAR, '0);
        offer(CMD_QUERY, ones);

        for (int p = 0; p < PHASES; p++)
        begin
            apply_config(width_plan[p], {11'($urandom), count_plan[p]}, p == 3);
            tx_steady = (p == 5);
            rx_steady = (p == 5);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 2 && k == 10)
                begin
                    hold_request = 1'b1;
                    tx_steady = 1'b1;
                end
                if (p == 2 && k == 30)
                    tx_steady = 1'b0;
                if (p == 4 && k == 30)
                    drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.present_due.size() != 0)
        begin
            $error("present: %0d queries never answered", sb.present_due.size());
            sb.errors++;
        end

        $display("ran %0d inserts, %0d queries (%0d hits), %0d clears, %0d unused commands",
                 sb.inserts, sb.queries, sb.hits, sb.clears, sb.ignored);
        $display("%0d register writes across %0d settings, %0d answers checked, %0d errors",
                 sb.reg_writes, PHASES + 5, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
